FILE: rtl/apl_pkg.sv
package apl_pkg;

  // sizing
  localparam int MAX_POINTS    = 64;
  localparam int CORDIC_STAGES = 18;
  localparam int ANG_W         = 23;  // working angle, Q4.16 with wrap headroom
  localparam int Z_W           = 38;  // residual angle, Q30
  localparam int XY_W          = 34;  // cordic x / y, Q30
  localparam int STEP_W        = 20;
  localparam int DVD_W         = 47;  // segment_length << 16
  localparam int CNT_W         = $clog2(MAX_POINTS);
  localparam int IDX_W         = 5;

  // angle constants
  localparam logic signed [ANG_W-1:0] ANG_2PI  = 23'sd411775;
  localparam logic [STEP_W-1:0]       ANG_ONE  = 20'd65536;
  localparam logic [STEP_W-1:0]       STEP_MAX = 20'd1048575;
  localparam logic signed [Z_W-1:0]   Q30_PI      = 38'sd3373259426;
  localparam logic signed [Z_W-1:0]   Q30_HALF_PI = 38'sd1686629713;
  localparam logic signed [Z_W-1:0]   Q30_2PI     = 38'sd6746518852;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic signed [19:0] start_angle;
    logic signed [19:0] end_angle;
    logic               clockwise;
    logic signed [31:0] segment_length;
    logic [18:0]        step_angle;
  } apl_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last;
  } apl_out_t;

  // arctangent of 2^-i in Q30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({{(Z_W-32){1'b0}}, v});
  endfunction

endpackage

FILE: rtl/arc_polyline_points_core.sv
// Arc to polyline: one request beat yields the start vertex, up to
// MAX_POINTS-2 interior vertices and the end vertex (last=1). The block
// takes one request at a time and holds in_stall high until the end vertex
// is delivered. A positive segment_length with a nonzero radius first
// runs a bit-serial divider. Each vertex then goes through the shared
// CORDIC unit (which wraps the angle by 2*pi, 0 to 2 times), then the
// shared multiplier, add and saturate, and the output beat.
module arc_polyline_points_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  apl_pkg::apl_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output apl_pkg::apl_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_ROT_GO, S_ROT, S_MX, S_AX, S_AY, S_OUT
  } st_t;

  st_t                                st_r;
  apl_pkg::apl_in_t                   req_r;
  logic [apl_pkg::STEP_W-1:0]         step_r, step_in;
  logic signed [apl_pkg::ANG_W-1:0]   lim_r, lim_in, ang_r, ang_nx, ea_in, a1_in;
  logic [apl_pkg::CNT_W-1:0]          n_r;
  logic                               fin_r, out_valid_r, in_acc, div_need;
  logic signed [apl_pkg::XY_W-1:0]    c_r, s_r, cos_q, sin_q;
  logic signed [65:0]                 prod_r, mul_res;
  logic signed [31:0]                 px_r, py_r, coord_v;
  logic signed [31:0]                 ctr_sel;
  logic signed [65:0]                 rnd;
  logic signed [36:0]                 vsum;
  logic                               div_done, cord_done, more;
  logic [apl_pkg::DVD_W-1:0]          quot;
  logic [apl_pkg::STEP_W-1:0]         step_div;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);
  assign div_need = (in_data.segment_length > 0) && (in_data.radius != '0);

  // step and wrap limit from the request
  always_comb begin
    a1_in = apl_pkg::ANG_W'(in_data.start_angle);
    ea_in = apl_pkg::ANG_W'(in_data.end_angle);
    if (in_data.segment_length <= 0 && in_data.step_angle != '0) begin
      step_in = apl_pkg::STEP_W'(in_data.step_angle);
    end else if (in_data.segment_length > 0) begin
      step_in = apl_pkg::STEP_MAX;
    end else begin
      step_in = apl_pkg::ANG_ONE;
    end
    if (!in_data.clockwise) begin
      lim_in = (a1_in >= ea_in) ? ea_in + apl_pkg::ANG_2PI : ea_in;
    end else begin
      lim_in = (a1_in <= ea_in) ? ea_in - apl_pkg::ANG_2PI : ea_in;
    end
  end

  // quotient clamp
  always_comb begin
    if (|quot[apl_pkg::DVD_W-1:apl_pkg::STEP_W]) begin
      step_div = apl_pkg::STEP_MAX;
    end else if (quot[apl_pkg::STEP_W-1:0] == '0) begin
      step_div = apl_pkg::STEP_W'(1);
    end else begin
      step_div = quot[apl_pkg::STEP_W-1:0];
    end
  end

  // next interior angle and whether it is emitted
  always_comb begin
    ang_nx = req_r.clockwise ? ang_r - $signed({3'b0, step_r})
                             : ang_r + $signed({3'b0, step_r});
    more   = (req_r.clockwise ? (ang_nx >= lim_r) : (ang_nx <= lim_r))
             && (n_r < apl_pkg::CNT_W'(apl_pkg::MAX_POINTS - 2));
  end

  // shared multiplier and rounding add with saturation
  always_comb begin
    mul_res = (st_r == S_MX ? c_r : s_r) * $signed({1'b0, req_r.radius});
    ctr_sel = (st_r == S_AX) ? req_r.center_x : req_r.center_y;
    rnd     = prod_r + 66'sd536870912;
    vsum    = 37'(ctr_sel) + 37'($signed(rnd[65:30]));
    if (vsum > 37'sd2147483647) begin
      coord_v = 32'sh7FFFFFFF;
    end else if (vsum < -37'sd2147483648) begin
      coord_v = 32'sh80000000;
    end else begin
      coord_v = vsum[31:0];
    end
  end

  apl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && div_need),
    .dividend ({in_data.segment_length[30:0], 16'b0}),
    .divisor  (in_data.radius),
    .done     (div_done),
    .quot     (quot)
  );

  apl_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == S_ROT_GO),
    .ang   (ang_r),
    .done  (cord_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r  <= in_data;
            step_r <= step_in;
            lim_r  <= lim_in;
            ang_r  <= a1_in;
            n_r    <= '0;
            fin_r  <= 1'b0;
            st_r   <= div_need ? S_DIV : S_ROT_GO;
          end
        end
        S_DIV: begin
          if (div_done) begin
            step_r <= step_div;
            st_r   <= S_ROT_GO;
          end
        end
        S_ROT_GO: st_r <= S_ROT;
        S_ROT: begin
          if (cord_done) begin
            c_r  <= cos_q;
            s_r  <= sin_q;
            st_r <= S_MX;
          end
        end
        S_MX: begin
          prod_r <= mul_res;
          st_r   <= S_AX;
        end
        S_AX: begin
          px_r   <= coord_v;
          prod_r <= mul_res;
          st_r   <= S_AY;
        end
        S_AY: begin
          py_r        <= coord_v;
          out_valid_r <= 1'b1;
          st_r        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (fin_r) begin
              st_r <= S_IDLE;
            end else begin
              if (more) begin
                ang_r <= ang_nx;
                n_r   <= n_r + 1'b1;
              end else begin
                ang_r <= apl_pkg::ANG_W'(req_r.end_angle);
                fin_r <= 1'b1;
              end
              st_r <= S_ROT_GO;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data.point_x = px_r;
  assign out_data.point_y = py_r;
  assign out_data.last    = fin_r;

  // checks
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT)
    else $error("result beat outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= apl_pkg::CNT_W'(apl_pkg::MAX_POINTS - 2))
    else $error("interior count beyond cap");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !in_stall)
    else $error("not idle after end vertex");

endmodule

FILE: rtl/apl_div.sv
module apl_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [apl_pkg::DVD_W-1:0]  dividend,
  input  logic [30:0]                divisor,
  output logic                       done,
  output logic [apl_pkg::DVD_W-1:0]  quot
);

  logic [apl_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [30:0]               rem_r, rem_nxt;
  logic [30:0]               dv_r;
  logic [5:0]                cnt_r;
  logic                      run_r, done_r;
  logic [31:0]               rem_sh;
  logic                      ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, q_r[apl_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dv_r};
    rem_nxt = ge ? 31'(rem_sh - {1'b0, dv_r}) : rem_sh[30:0];
    q_nxt   = {q_r[apl_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        q_r   <= dividend;
        rem_r <= '0;
        dv_r  <= divisor;
      end else if (run_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(apl_pkg::DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/apl_cordic.sv
module apl_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [apl_pkg::ANG_W-1:0]  ang,
  output logic                              done,
  output logic signed [apl_pkg::XY_W-1:0]   cos_q,
  output logic signed [apl_pkg::XY_W-1:0]   sin_q
);

  typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD, C_ROT, C_DONE} cst_t;

  cst_t                            st_r;
  logic signed [apl_pkg::Z_W-1:0]  z_r;
  logic signed [apl_pkg::XY_W-1:0] x_r, y_r;
  logic [apl_pkg::IDX_W-1:0]       i_r;
  logic                            neg_r;
  logic signed [apl_pkg::XY_W-1:0] xs, ys;
  logic signed [apl_pkg::Z_W-1:0]  at;

  // one micro-rotation per cycle
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = apl_pkg::atan_q30(i_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      case (st_r)
        C_IDLE: begin
          if (start) begin
            z_r  <= {{(apl_pkg::Z_W-apl_pkg::ANG_W-14){ang[apl_pkg::ANG_W-1]}}, ang, 14'b0};
            st_r <= C_RED;
          end
        end
        // wrap into [-pi, pi], one turn per cycle
        C_RED: begin
          if (z_r > apl_pkg::Q30_PI) begin
            z_r <= z_r - apl_pkg::Q30_2PI;
          end else if (z_r < -apl_pkg::Q30_PI) begin
            z_r <= z_r + apl_pkg::Q30_2PI;
          end else begin
            st_r <= C_FOLD;
          end
        end
        // fold into the right half plane
        C_FOLD: begin
          neg_r <= 1'b0;
          if (z_r > apl_pkg::Q30_HALF_PI) begin
            z_r   <= z_r - apl_pkg::Q30_PI;
            neg_r <= 1'b1;
          end else if (z_r < -apl_pkg::Q30_HALF_PI) begin
            z_r   <= z_r + apl_pkg::Q30_PI;
            neg_r <= 1'b1;
          end
          x_r  <= apl_pkg::CORDIC_GAIN;
          y_r  <= '0;
          i_r  <= '0;
          st_r <= C_ROT;
        end
        C_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          i_r <= i_r + 1'b1;
          if (i_r == apl_pkg::IDX_W'(apl_pkg::CORDIC_STAGES - 1)) begin
            st_r <= C_DONE;
          end
        end
        C_DONE: begin
          st_r <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign done  = (st_r == C_DONE);
  assign cos_q = neg_r ? -x_r : x_r;
  assign sin_q = neg_r ? -y_r : y_r;

endmodule

FILE: dv/tb_arc_polyline_points_core.sv
`timescale 1ns / 100ps

module tb_arc_polyline_points_core;

  localparam longint LIMIT_CYC = 4000000;
  localparam longint TWO_PI_Q416 = 411775;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  apl_pkg::apl_in_t   in_data;
  logic               out_valid;
  logic               out_stall;
  apl_pkg::apl_out_t  out_data;

  apl_pkg::apl_out_t vertex_q[$];
  int       err_cnt = 0;
  longint   cyc = 0;
  bit       send_idle_en;
  bit       recv_idle_en;

  arc_polyline_points_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // arctangent table, q30
  function automatic longint atan_tab(input int i);
    longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // rotate gain vector to angle (q4.16), giving cos/sin in q30
  task automatic rotate_q30(input longint ang, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = ang * 16384;
    x = 652032874;
    y = 0;
    flip = 0;
    while (z > 64'sd3373259426) z -= 64'sd6746518852;
    while (z < -64'sd3373259426) z += 64'sd6746518852;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < apl_pkg::CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab(i);
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] offset_sat(input longint ctr, input longint trig,
                                             input longint r);
    longint v;
    v = ctr + ((trig * r + (64'sd1 <<< 29)) >>> 30);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic add_vertex(input apl_pkg::apl_in_t req, input longint ang, input bit fin);
    longint c, s;
    apl_pkg::apl_out_t p;
    rotate_q30(ang, c, s);
    p.point_x = offset_sat(longint'(req.center_x), c, longint'(req.radius));
    p.point_y = offset_sat(longint'(req.center_y), s, longint'(req.radius));
    p.last    = fin;
    vertex_q.insert(vertex_q.size(), p);
  endtask

  // expected vertices of one arc request
  task automatic predict_arc(input apl_pkg::apl_in_t req);
    longint r, a1, lim, seg, sa, step, a, q;
    int n;
    r   = longint'(req.radius);
    a1  = longint'(req.start_angle);
    lim = longint'(req.end_angle);
    seg = longint'(req.segment_length);
    sa  = longint'(req.step_angle);
    if (seg <= 0 && sa > 0) step = sa;
    else if (seg > 0) begin
      if (r == 0) step = 1048575;
      else begin
        q = (seg <<< 16) / r;
        step = (q > 1048575) ? 1048575 : q;
        if (step == 0) step = 1;
      end
    end else step = 65536;
    n = 0;
    add_vertex(req, a1, 1'b0);
    if (!req.clockwise) begin
      if (a1 >= lim) lim += TWO_PI_Q416;
      for (a = a1 + step; a <= lim && n < apl_pkg::MAX_POINTS - 2; a += step, n++)
        add_vertex(req, a, 1'b0);
    end else begin
      if (a1 <= lim) lim -= TWO_PI_Q416;
      for (a = a1 - step; a >= lim && n < apl_pkg::MAX_POINTS - 2; a -= step, n++)
        add_vertex(req, a, 1'b0);
    end
    add_vertex(req, longint'(req.end_angle), 1'b1);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
  endtask

  // result checker
  always @(posedge clk) begin
    apl_pkg::apl_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) report_mismatch("unexpected beat", out_data.point_x, 0);
      else begin
        w = vertex_q.pop_front();
        if (out_data.point_x !== w.point_x)
          report_mismatch("point_x", out_data.point_x, w.point_x);
        if (out_data.point_y !== w.point_y)
          report_mismatch("point_y", out_data.point_y, w.point_y);
        if (out_data.last !== w.last)
          report_mismatch("last", 32'(out_data.last), 32'(w.last));
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // send one request beat, wait for acceptance
  task automatic send_arc(input apl_pkg::apl_in_t req);
    if (send_idle_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 15)) @(posedge clk);
    predict_arc(req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    // block stays busy after a request beat until its end vertex is delivered
    @(posedge clk);
  endtask

  task automatic drain_vertices();
    while (vertex_q.size() != 0) @(posedge clk);
  endtask

  function automatic apl_pkg::apl_in_t make_arc(input int cx, input int cy, input int r,
                                                input int a1, input int a2, input bit cw,
                                                input int seg, input int sa);
    apl_pkg::apl_in_t q;
    q.center_x = cx;
    q.center_y = cy;
    q.radius = r[30:0];
    q.start_angle = a1[19:0];
    q.end_angle = a2[19:0];
    q.clockwise = cw;
    q.segment_length = seg;
    q.step_angle = sa[18:0];
    return q;
  endfunction

  function automatic apl_pkg::apl_in_t rand_arc();
    apl_pkg::apl_in_t q;
    logic [191:0] rbits;
    int sel;
    rbits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = rbits[$bits(apl_pkg::apl_in_t)-1:0];
    sel = $urandom_range(0, 9);
    // mostly moderate arcs with modest point counts
    if (sel < 7) begin
      q.start_angle = 20'($signed($urandom_range(0, 823550)) - 411775);
      q.end_angle   = 20'($signed($urandom_range(0, 823550)) - 411775);
      q.step_angle  = 19'($urandom_range(6000, 411775));
      case ($urandom_range(0, 3))
        0: q.segment_length = 0;
        1: q.segment_length = -$signed(32'($urandom_range(1, 1000000)));
        2: begin
          q.radius = 31'($urandom_range(1, 32'h7FFFFFFF));
          q.segment_length = 32'(longint'(q.radius) / $urandom_range(1, 30) + 1);
        end
        default: ;
      endcase
    end
    return q;
  endfunction

  task automatic test_extremes();
    send_arc(make_arc(0, 0, 65536, 0, 102944, 0, 0, 16384));
    send_arc(make_arc(0, 0, 65536, 0, 102944, 1, 0, 16384));
    send_arc(make_arc(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 205887, 0, 0, 51471));
    send_arc(make_arc(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, -411775, 411775, 1, -1, 0));
    send_arc(make_arc(12345, -999, 0, 1000, 5000, 0, 65536, 0));
    send_arc(make_arc(0, 0, 1, 0, 411775, 0, 32'h7FFFFFFF, 0));
    send_arc(make_arc(100, 200, 32'h7FFFFFFF, 0, 100, 0, 1, 0));
    send_arc(make_arc(0, 0, 655360, 50000, 50000, 0, 0, 0));
    send_arc(make_arc(0, 0, 655360, 50000, 50000, 1, 32'h80000000, 0));
    send_arc(make_arc(0, 0, 655360, 0, 1000, 0, 0, 1));
    send_arc(make_arc(0, 0, 655360, 0, -1000, 1, 0, 1));
    send_arc(make_arc(7, 7, 655360, 411775, -411775, 0, 0, 411775));
    send_arc(make_arc(7, 7, 655360, -411775, 411775, 1, 0, 411775));
    send_arc(make_arc(0, 0, 655360, 20'h7FFFF, 20'h80000, 0, 0, 19'h7FFFF));
    send_arc(make_arc(0, 0, 655360, 20'h80000, 20'h7FFFF, 1, 0, 19'h7FFFF));
    send_arc(make_arc(0, 0, 4096, 10000, 9000, 0, 300000, 0));
  endtask

  task automatic test_quiet_pause();
    send_arc(make_arc(-65536, 65536, 131072, 0, 300000, 0, 0, 30000));
    drain_vertices();
    send_arc(make_arc(65536, -65536, 131072, 300000, 0, 1, 20000, 0));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_arc(rand_arc());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_en = 1;
    recv_idle_en = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_quiet_pause();
    test_random(200);
    // last part with no idling
    send_idle_en = 0;
    recv_idle_en = 0;
    test_random(60);
    drain_vertices();
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && vertex_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
